>>> rtl/core/dcad_pkg.sv
// dcad_pkg: shared types and constants of the dual channel anomaly detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dcad_pkg;
	localparam int LEVEL_W = 15;
	localparam int LEN_W = 7;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd25600;

	localparam logic [2:0] REG_CPU_LEVEL = 3'd0;
	localparam logic [2:0] REG_RAM_LEVEL = 3'd1;
	localparam logic [2:0] REG_CPU_RISE = 3'd2;
	localparam logic [2:0] REG_RAM_RISE = 3'd3;
	localparam logic [2:0] REG_CPU_TREND = 3'd4;
	localparam logic [2:0] REG_RAM_TREND = 3'd5;
	localparam logic [2:0] REG_WIN_LEN = 3'd6;

	localparam logic [1:0] KIND_THRESHOLD = 2'd0;
	localparam logic [1:0] KIND_SPIKE = 2'd1;
	localparam logic [1:0] KIND_TREND = 2'd2;

	// per lane limits
	typedef struct packed {
		logic [LEVEL_W-1:0] level_limit;
		logic [LEVEL_W-1:0] rise_limit;
		logic [LEVEL_W-1:0] trend_limit;
	} lane_cfg_t;

	// findings of one lane for one request
	typedef struct packed {
		logic                thr_hit;
		logic                spike_hit;
		logic                trend_hit;
		logic [LEVEL_W-1:0]  level;
		logic [LEVEL_W-1:0]  thr_ref;
		logic [LEVEL_W-1:0]  rise;
		logic [LEVEL_W-1:0]  mean;
	} lane_res_t;
endpackage
`default_nettype wire

>>> rtl/core/dcad_lane.sv
// dcad_lane: one channel window, threshold, spike and trend check with a serial mean divider
// depends on dcad_pkg
`timescale 1ns / 1ps
`default_nettype none
module dcad_lane #(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic [dcad_pkg::LEN_W-1:0] win_len,
	input  wire dcad_pkg::lane_cfg_t        cfg,
	input  wire logic                       start,
	input  wire logic                       present,
	input  wire logic [dcad_pkg::LEVEL_W-1:0] sample,
	output logic                            done,
	output dcad_pkg::lane_res_t             res
);
	import dcad_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int SW = LEVEL_W + FW;
	localparam int LW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_UPD, ST_DIV, ST_DONE} st_t;
	st_t st_q;

	logic [LEVEL_W-1:0] mem [MAX_WINDOW];
	logic [LEVEL_W-1:0] old_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] slot_q;
	logic [SW-1:0] sum_q;
	logic [LEVEL_W-1:0] prev_q, prev_old_q, samp_q;
	logic pres_q, full_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [$clog2(SW+1)-1:0] cnt_q;
	logic [LW-1:0] len;
	logic [SW:0] trial;

	assign len = LW'(win_len);
	assign trial = {rem_q, quo_q[SW-1]} - {{(SW+1-LW){1'b0}}, len};

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start && present) old_q <= mem[slot_q];
		if (st_q == ST_UPD && pres_q) mem[slot_q] <= samp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			fill_q <= '0;
			slot_q <= '0;
			sum_q <= '0;
			prev_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (clear) begin
				fill_q <= '0;
				slot_q <= '0;
				sum_q <= '0;
			end
			case (st_q)
				ST_IDLE: if (start) begin
					pres_q <= present;
					samp_q <= (sample > FULL_SCALE) ? FULL_SCALE : sample;
					prev_old_q <= prev_q;
					st_q <= ST_READ;
				end
				ST_READ: st_q <= ST_UPD;
				ST_UPD: begin
					if (pres_q) begin
						if (fill_q >= FW'(len)) begin
							sum_q <= sum_q - SW'(old_q) + SW'(samp_q);
						end else begin
							sum_q <= sum_q + SW'(samp_q);
							fill_q <= fill_q + 1'b1;
						end
						slot_q <= (LW'(slot_q) + 1'b1 >= len) ? '0 : slot_q + 1'b1;
						prev_q <= samp_q;
					end
					quo_q <= '0;
					rem_q <= '0;
					cnt_q <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 0) begin
						quo_q <= sum_q;
						full_q <= (fill_q >= FW'(len));
						cnt_q <= cnt_q + 1'b1;
					end else if (cnt_q == SW + 1) begin
						st_q <= ST_DONE;
					end else begin
						if (!trial[SW]) begin
							rem_q <= trial[SW-1:0];
							quo_q <= {quo_q[SW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
							quo_q <= {quo_q[SW-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	logic [LEVEL_W-1:0] mean;
	assign mean = quo_q[LEVEL_W-1:0];

	always_comb begin
		res.level = samp_q;
		res.thr_ref = cfg.level_limit;
		res.rise = samp_q - prev_old_q;
		res.mean = mean;
		res.thr_hit = pres_q && samp_q > cfg.level_limit;
		res.spike_hit = pres_q && fill_q >= FW'(2) && samp_q > prev_old_q
			&& (samp_q - prev_old_q) > cfg.rise_limit;
		res.trend_hit = pres_q && full_q && samp_q > mean
			&& (samp_q - mean) > cfg.trend_limit;
	end
endmodule
`default_nettype wire

>>> rtl/core/dcad_merge.sv
// dcad_merge: orders lane findings into up to six alerts and drives the output register
// depends on dcad_pkg
`timescale 1ns / 1ps
`default_nettype none
module dcad_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire dcad_pkg::lane_res_t cpu_res,
	input  wire dcad_pkg::lane_res_t ram_res,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     resource,
	output logic [1:0]               kind,
	output logic                     severity,
	output logic [dcad_pkg::LEVEL_W-1:0] level,
	output logic [dcad_pkg::LEVEL_W-1:0] reference,
	output logic                     last
);
	import dcad_pkg::*;

	logic [5:0] pend_q;
	lane_res_t cpu_q, ram_q;
	logic [2:0] idx;
	logic [5:0] rest;

	always_comb begin
		idx = '0;
		for (int i = 5; i >= 0; i--) if (pend_q[i]) idx = 3'(i);
		rest = pend_q & ~(6'd1 << idx);
	end

	assign busy = (pend_q != '0) || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				cpu_q <= cpu_res;
				ram_q <= ram_res;
				pend_q <= {ram_res.trend_hit, cpu_res.trend_hit, ram_res.spike_hit,
					cpu_res.spike_hit, ram_res.thr_hit, cpu_res.thr_hit};
			end else if (pend_q != '0 && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
				resource <= idx[0];
				severity <= (idx >= 3'd4);
				last <= (rest == '0);
				case (idx)
					3'd0: begin kind <= KIND_THRESHOLD; level <= cpu_q.level;
						reference <= cpu_q.thr_ref; end
					3'd1: begin kind <= KIND_THRESHOLD; level <= ram_q.level;
						reference <= ram_q.thr_ref; end
					3'd2: begin kind <= KIND_SPIKE; level <= cpu_q.level;
						reference <= cpu_q.rise; end
					3'd3: begin kind <= KIND_SPIKE; level <= ram_q.level;
						reference <= ram_q.rise; end
					3'd4: begin kind <= KIND_TREND; level <= cpu_q.level;
						reference <= cpu_q.mean; end
					default: begin kind <= KIND_TREND; level <= ram_q.level;
						reference <= ram_q.mean; end
				endcase
				pend_q <= rest;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/dual_channel_anomaly_detector_unit.sv
// dual_channel_anomaly_detector_unit: top level of the anomaly detector
// depends on dcad_pkg, dcad_lane, dcad_merge
`timescale 1ns / 1ps
`default_nettype none
// Two identical lanes (cpu, ram) each keep a sliding window of present samples
// in a local memory, update the running sum, and divide it by the window length
// with a one-bit-per-cycle restoring divider; a merge stage then emits up to six
// alerts in order cpu/ram threshold, spike, trend, flagging the final one with
// last. Each lane steps through its read, update, divide and done states after a
// request is taken. The merge stage loads when both lanes report done and issues
// one alert per cycle while out_ready stays high. An item with no alerts gives no
// output. The next request is accepted once the previous one's alerts have all
// been accepted by the receiver.
// Writing window_length (clamped to 2..MAX_WINDOW) empties both windows.
module dual_channel_anomaly_detector_unit #(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cpu_present,
	input  wire logic [14:0] cpu_level,
	input  wire logic        ram_present,
	input  wire logic [14:0] ram_level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             resource,
	output logic [1:0]       kind,
	output logic             severity,
	output logic [14:0]      level,
	output logic [14:0]      reference,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import dcad_pkg::*;

	lane_cfg_t cpu_cfg_q, ram_cfg_q;
	logic [LEN_W-1:0] win_len_q;
	logic clear;
	logic busy_q;
	logic cpu_done, ram_done, merge_busy;
	lane_res_t cpu_res, ram_res;
	logic start;
	logic [LEN_W-1:0] wr_len;

	// clamp written length to 2..MAX_WINDOW
	assign wr_len = (cfg_data[LEN_W-1:0] < LEN_W'(2)) ? LEN_W'(2) :
		(32'(cfg_data[LEN_W-1:0]) > MAX_WINDOW) ? LEN_W'(MAX_WINDOW) : cfg_data[LEN_W-1:0];

	assign cfg_ready = 1'b1;
	assign in_ready = !busy_q && !merge_busy;
	assign start = in_valid && in_ready;
	assign clear = cfg_valid && cfg_index == REG_WIN_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_cfg_q <= '{15'd20480, 15'd7680, 15'd5120};
			ram_cfg_q <= '{15'd20480, 15'd7680, 15'd5120};
			win_len_q <= (MAX_WINDOW < 8) ? LEN_W'(MAX_WINDOW) : LEN_W'(8);
			busy_q <= 1'b0;
		end else begin
			if (start) busy_q <= 1'b1;
			else if (cpu_done) busy_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_CPU_LEVEL: cpu_cfg_q.level_limit <= cfg_data[14:0];
					REG_RAM_LEVEL: ram_cfg_q.level_limit <= cfg_data[14:0];
					REG_CPU_RISE: cpu_cfg_q.rise_limit <= cfg_data[14:0];
					REG_RAM_RISE: ram_cfg_q.rise_limit <= cfg_data[14:0];
					REG_CPU_TREND: cpu_cfg_q.trend_limit <= cfg_data[14:0];
					REG_RAM_TREND: ram_cfg_q.trend_limit <= cfg_data[14:0];
					REG_WIN_LEN: win_len_q <= wr_len;
					default: ;
				endcase
			end
		end
	end

	dcad_lane #(.MAX_WINDOW(MAX_WINDOW)) u_cpu (
		.clk(clk), .arst_n(arst_n), .clear(clear), .win_len(win_len_q), .cfg(cpu_cfg_q),
		.start(start), .present(cpu_present), .sample(cpu_level),
		.done(cpu_done), .res(cpu_res));

	dcad_lane #(.MAX_WINDOW(MAX_WINDOW)) u_ram (
		.clk(clk), .arst_n(arst_n), .clear(clear), .win_len(win_len_q), .cfg(ram_cfg_q),
		.start(start), .present(ram_present), .sample(ram_level),
		.done(ram_done), .res(ram_res));

	dcad_merge u_merge (
		.clk(clk), .arst_n(arst_n), .load(cpu_done && ram_done),
		.cpu_res(cpu_res), .ram_res(ram_res), .busy(merge_busy),
		.out_valid(out_valid), .out_ready(out_ready), .resource(resource), .kind(kind),
		.severity(severity), .level(level), .reference(reference), .last(last));
endmodule
`default_nettype wire

>>> tb/dual_channel_anomaly_detector_unit_test.sv
// dual_channel_anomaly_detector_unit_test: self-checking bench for the anomaly detector
// drives sample requests and register writes, predicts alerts, checks every accepted alert
// depends on dcad_pkg and dual_channel_anomaly_detector_unit
`timescale 1ns / 1ps
`default_nettype none
module dual_channel_anomaly_detector_unit_test;
	import dcad_pkg::*;

	localparam int MAXW = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	// one sample request
	typedef struct packed {
		logic        cpu_p;
		logic [14:0] cpu_l;
		logic        ram_p;
		logic [14:0] ram_l;
	} sample_req_t;

	// one alert
	typedef struct packed {
		logic        res;
		logic [1:0]  knd;
		logic        sev;
		logic [14:0] lvl;
		logic [14:0] refv;
		logic        lst;
	} alert_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cpu_present = 1'b0;
	logic [14:0] cpu_level = '0;
	logic ram_present = 1'b0;
	logic [14:0] ram_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic resource;
	logic [1:0] kind;
	logic severity;
	logic [14:0] level;
	logic [14:0] reference;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	dual_channel_anomaly_detector_unit #(.MAX_WINDOW(MAXW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cpu_present(cpu_present), .cpu_level(cpu_level),
		.ram_present(ram_present), .ram_level(ram_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.resource(resource), .kind(kind), .severity(severity),
		.level(level), .reference(reference), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state: per channel window, fill, slot, sum, previous
	logic [14:0] win_store [2][MAXW];
	int unsigned win_fill [2];
	int unsigned win_slot [2];
	int unsigned win_sum [2];
	logic [14:0] prev_level [2];
	logic [14:0] lim_level [2];
	logic [14:0] lim_rise [2];
	logic [14:0] lim_trend [2];
	int unsigned win_len;

	alert_t pending_alerts[$];
	sample_req_t req_queue[$];
	int unsigned fail_count = 0;
	logic calm = 1'b0;      // no idling on either side while set
	logic in_taken_q = 1'b0; // request accepted at the last rising edge

	function automatic int unsigned clamp_len(logic [6:0] v);
		if (v < 2) return 2;
		if (v > MAXW) return MAXW;
		return v;
	endfunction

	function automatic void clear_windows();
		for (int c = 0; c < 2; c++) begin
			win_fill[c] = 0;
			win_slot[c] = 0;
			win_sum[c] = 0;
		end
	endfunction

	// mirror a register write into the predictor
	function automatic void track_register(logic [2:0] idx, logic [31:0] data);
		case (idx)
			REG_CPU_LEVEL: lim_level[0] = data[14:0];
			REG_RAM_LEVEL: lim_level[1] = data[14:0];
			REG_CPU_RISE: lim_rise[0] = data[14:0];
			REG_RAM_RISE: lim_rise[1] = data[14:0];
			REG_CPU_TREND: lim_trend[0] = data[14:0];
			REG_RAM_TREND: lim_trend[1] = data[14:0];
			REG_WIN_LEN: begin
				win_len = clamp_len(data[6:0]);
				clear_windows();
			end
			default: ;
		endcase
	endfunction

	// compute the alerts raised by one accepted request
	function automatic void predict_alerts(sample_req_t r);
		logic pres [2];
		logic [14:0] samp [2];
		logic [14:0] prv [2];
		alert_t found[$];
		alert_t a;
		int unsigned mean;
		pres[0] = r.cpu_p;
		pres[1] = r.ram_p;
		samp[0] = (r.cpu_l > FULL_SCALE) ? FULL_SCALE : r.cpu_l;
		samp[1] = (r.ram_l > FULL_SCALE) ? FULL_SCALE : r.ram_l;
		for (int c = 0; c < 2; c++) begin
			prv[c] = prev_level[c];
			if (pres[c]) begin
				if (win_fill[c] >= win_len)
					win_sum[c] -= win_store[c][win_slot[c]];
				else
					win_fill[c]++;
				win_store[c][win_slot[c]] = samp[c];
				win_sum[c] += samp[c];
				win_slot[c] = (win_slot[c] + 1 >= win_len) ? 0 : win_slot[c] + 1;
				prev_level[c] = samp[c];
			end
		end
		for (int c = 0; c < 2; c++)
			if (pres[c] && samp[c] > lim_level[c]) begin
				a = '{c[0], KIND_THRESHOLD, 1'b0, samp[c], lim_level[c], 1'b0};
				found = {found, a};
			end
		for (int c = 0; c < 2; c++)
			if (pres[c] && win_fill[c] >= 2 && samp[c] > prv[c]
					&& samp[c] - prv[c] > lim_rise[c]) begin
				a = '{c[0], KIND_SPIKE, 1'b0, samp[c], 15'(samp[c] - prv[c]), 1'b0};
				found = {found, a};
			end
		for (int c = 0; c < 2; c++)
			if (pres[c] && win_fill[c] >= win_len) begin
				mean = win_sum[c] / win_len;
				if (samp[c] > mean && samp[c] - mean > lim_trend[c]) begin
					a = '{c[0], KIND_TREND, 1'b1, samp[c], 15'(mean), 1'b0};
					found = {found, a};
				end
			end
		if (found.size() > 0)
			found[found.size()-1].lst = 1'b1;
		foreach (found[i])
			pending_alerts = {pending_alerts, found[i]};
	endfunction

	always @(posedge clk)
		in_taken_q <= in_valid && in_ready;

	// driver: issue queued requests, valid held until accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken_q) begin
				// hold the request
			end else if (req_queue.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
				in_valid <= 1'b1;
				{cpu_present, cpu_level, ram_present, ram_level} <= req_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	int unsigned idle_cycles = 0;

	// monitor: predict on accepted requests, compare accepted alerts
	always @(posedge clk) begin
		alert_t got;
		alert_t exp_a;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_alerts({cpu_present, cpu_level, ram_present, ram_level});
			if (out_valid && out_ready) begin
				got = '{resource, kind, severity, level, reference, last};
				if (pending_alerts.size() == 0) begin
					$display("%0t: unexpected alert, expected none, actual %p", $time, got);
					fail_count++;
				end else begin
					exp_a = pending_alerts.pop_front();
					if (got !== exp_a) begin
						$display("%0t: alert mismatch, expected %p, actual %p",
							$time, exp_a, got);
						fail_count++;
					end
				end
			end
			// watchdog on cycles without any handshake
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
					|| (req_queue.size() == 0 && !in_valid && pending_alerts.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("dual_channel_anomaly_detector_unit_test failed");
				$finish;
			end
		end
	end

	// wait until every queued request is taken and every alert has come
	task automatic drain();
		while (req_queue.size() > 0 || in_valid || pending_alerts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		track_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void queue_req(logic cp, logic [14:0] cl, logic rp, logic [14:0] rl);
		sample_req_t r;
		r = '{cp, cl, rp, rl};
		req_queue = {req_queue, r};
	endfunction

	// random level biased toward limits and full scale, sometimes above it
	function automatic logic [14:0] rand_level();
		case ($urandom_range(5))
			0: return 15'($urandom_range(32767));
			1: return 15'($urandom_range(25600, 20000));
			2: return 15'($urandom_range(1000));
			default: return 15'($urandom_range(25600));
		endcase
	endfunction

	// random requests, each channel present most of the time
	task automatic queue_burst(int n);
		for (int i = 0; i < n; i++)
			queue_req($urandom_range(9) != 0, rand_level(), $urandom_range(9) != 0, rand_level());
	endtask

	initial begin
		lim_level = '{15'd20480, 15'd20480};
		lim_rise = '{15'd7680, 15'd7680};
		lim_trend = '{15'd5120, 15'd5120};
		prev_level = '{15'd0, 15'd0};
		win_len = 8;
		clear_windows();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, saturation, spikes, trends under reset limits
		calm = 1'b1;
		queue_req(1'b1, 15'd0, 1'b1, 15'd0);
		queue_req(1'b1, 15'd32767, 1'b1, 15'd25600);   // saturated above full scale
		queue_req(1'b1, 15'd0, 1'b1, 15'd0);            // drop, no spike
		queue_req(1'b1, 15'd25600, 1'b0, 15'd32767);    // spike, ram absent
		queue_req(1'b0, 15'd0, 1'b1, 15'd20480);        // at limit, no threshold
		queue_req(1'b1, 15'd20481, 1'b1, 15'd20481);
		queue_req(1'b0, 15'd0, 1'b0, 15'd0);            // nothing present
		for (int i = 0; i < 8; i++)
			queue_req(1'b1, 15'd100, 1'b1, 15'd200);
		queue_req(1'b1, 15'd30000, 1'b1, 15'd32000);    // all six alerts
		queue_req(1'b1, 15'd25600, 1'b1, 15'd25600);
		queue_req(1'b1, 15'h5555, 1'b1, 15'h2AAA);
		queue_req(1'b1, 15'h2AAA, 1'b1, 15'h5555);
		drain();

		// short window, zero limits: every rise and excess fires
		calm = 1'b0;
		write_register(REG_WIN_LEN, 32'd0);   // clamped to two
		write_register(REG_CPU_LEVEL, 32'd0);
		write_register(REG_RAM_LEVEL, 32'hFFFF_8000);  // upper bits ignored
		write_register(REG_CPU_RISE, 32'd0);
		write_register(REG_RAM_RISE, 32'd0);
		write_register(REG_CPU_TREND, 32'd0);
		write_register(REG_RAM_TREND, 32'd0);
		write_register(3'd7, 32'd12345);      // unknown index
		queue_burst(60);
		drain();

		// longest window, maximal limits, then wait until drained
		write_register(REG_WIN_LEN, 32'd127);
		write_register(REG_CPU_LEVEL, 32'd32767);
		write_register(REG_RAM_LEVEL, 32'd25600);
		write_register(REG_CPU_RISE, 32'd32767);
		write_register(REG_RAM_RISE, 32'd25600);
		write_register(REG_CPU_TREND, 32'd32767);
		write_register(REG_RAM_TREND, 32'd25600);
		queue_burst(70);
		drain();

		// mid settings, random limits and windows, long calm stretch first
		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 0);
			write_register(REG_WIN_LEN, $urandom_range(2, 12));
			write_register(REG_CPU_LEVEL, $urandom_range(25600, 15000));
			write_register(REG_RAM_LEVEL, $urandom_range(25600, 15000));
			write_register(REG_CPU_RISE, $urandom_range(8000));
			write_register(REG_RAM_RISE, $urandom_range(8000));
			write_register(REG_CPU_TREND, $urandom_range(6000));
			write_register(REG_RAM_TREND, $urandom_range(6000));
			queue_burst(40);
			drain();
		end

		if (fail_count == 0)
			$display("dual_channel_anomaly_detector_unit_test passed");
		else
			$display("dual_channel_anomaly_detector_unit_test failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/dcad_pkg.sv
rtl/core/dcad_lane.sv
rtl/core/dcad_merge.sv
rtl/core/dual_channel_anomaly_detector_unit.sv
tb/dual_channel_anomaly_detector_unit_test.sv
